FILE: rtl/cubic_bezier_subcurve_bounds_unit_assert.svh
// Assertion macros shared by the subcurve bounds unit RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CUBIC_BEZIER_SUBCURVE_BOUNDS_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_SUBCURVE_BOUNDS_UNIT_ASSERT_SVH

// same-cycle implication
`define CBSB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cbsb_pkg.sv
// Shared constants and types for the cubic Bezier subcurve bounds unit.
// No dependencies.
`timescale 1ns / 1ps

package cbsb_pkg;

  localparam int CoordWidthDef = 32;
  localparam int ParamFracDef  = 16;

  // rel_margin is in 2^-24 units and scaled by 32 blossom ops: shift 24 - 5
  localparam int MarginShift = 19;
  localparam int CfgW        = 16;
  localparam int CfgIdxW     = 2;

  localparam logic [CfgW-1:0] RelMarginReset = 16'd1;
  localparam logic [CfgW-1:0] AbsMarginReset = 16'd4;

  // lane pipeline depth, input register to lane result register
  localparam int LaneDepth = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REL_MARGIN = 2'd0,
    CFG_ABS_MARGIN = 2'd1
  } cfg_reg_t;

endpackage

FILE: rtl/cbsb_lerp.sv
// Pipelined fixed-point lerp: a + round((b-a)*t / 2^PF), three stages.
// Depends on cbsb_pkg.
`timescale 1ns / 1ps

module cbsb_lerp
  import cbsb_pkg::*;
#(
  parameter int COORD_WIDTH     = CoordWidthDef,
  parameter int PARAM_FRAC_BITS = ParamFracDef
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [COORD_WIDTH-1:0]       a,
  input  logic [COORD_WIDTH-1:0]       b,
  input  logic [PARAM_FRAC_BITS:0]     t,
  output logic [COORD_WIDTH-1:0]       y
);

  localparam int CW = COORD_WIDTH;
  localparam int PF = PARAM_FRAC_BITS;
  localparam int PW = CW + PF + 3;
  localparam logic signed [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (PF - 1);

  logic signed [CW:0]   diff_r, diff_nxt;
  logic [CW-1:0]        a1_r, a2_r;
  logic [PF:0]          t_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [PW-1:0] rnd;
  logic [CW-1:0]        y_r, y_nxt;

  always_comb begin
    diff_nxt = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
    prod_nxt = diff_r * $signed({1'b0, t_r});
    rnd      = (prod_r + HALF) >>> PF;
    // result lies between a and b, so the low bits are exact
    y_nxt    = a2_r + rnd[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      a1_r   <= a;
      t_r    <= t;
      prod_r <= prod_nxt;
      a2_r   <= a1_r;
      y_r    <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

FILE: rtl/cbsb_lane.sv
// One axis lane: blossom restriction, margin, extent and mid value.
// Depends on cbsb_pkg and cbsb_lerp.
`timescale 1ns / 1ps

module cbsb_lane
  import cbsb_pkg::*;
#(
  parameter int COORD_WIDTH     = CoordWidthDef,
  parameter int PARAM_FRAC_BITS = ParamFracDef
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [COORD_WIDTH-1:0]   p0,
  input  logic [COORD_WIDTH-1:0]   p1,
  input  logic [COORD_WIDTH-1:0]   p2,
  input  logic [COORD_WIDTH-1:0]   p3,
  input  logic [PARAM_FRAC_BITS:0] t0,
  input  logic [PARAM_FRAC_BITS:0] t1,
  input  logic [CfgW-1:0]          rel_margin,
  input  logic [CfgW-1:0]          abs_margin,
  output logic [COORD_WIDTH-1:0]   q0,
  output logic [COORD_WIDTH-1:0]   q1,
  output logic [COORD_WIDTH-1:0]   q2,
  output logic [COORD_WIDTH-1:0]   q3,
  output logic [COORD_WIDTH-1:0]   ext_lo,
  output logic [COORD_WIDTH-1:0]   ext_hi,
  output logic [COORD_WIDTH-1:0]   mid,
  output logic [COORD_WIDTH-2:0]   margin
);

  localparam int CW = COORD_WIDTH;
  localparam int PF = PARAM_FRAC_BITS;
  localparam int MW = CW + CfgW;
  localparam int EW = CW + CfgW + 1;
  localparam int GW = CW + 3;
  localparam logic [EW-1:0] EMAX = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};

  function automatic logic [CW-1:0] half_lerp(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic signed [CW+1:0] d;
    logic signed [CW+1:0] s;
    begin
      d = $signed({{2{b[CW-1]}}, b}) - $signed({{2{a[CW-1]}}, a});
      s = (d + $signed({{(CW+1){1'b0}}, 1'b1})) >>> 1;
      half_lerp = a + s[CW-1:0];
    end
  endfunction

  function automatic logic [CW-1:0] magn(input logic [CW-1:0] v);
    magn = v[CW-1] ? (~v + {{(CW-1){1'b0}}, 1'b1}) : v;
  endfunction

  function automatic logic [CW-1:0] sat_sum(input logic signed [CW:0] s);
    if (s[CW] != s[CW-1]) sat_sum = {s[CW], {(CW-1){~s[CW]}}};
    else                  sat_sum = s[CW-1:0];
  endfunction

  // parameter delay line for the later blossom levels
  logic [PF:0] t0_d_r [1:6];
  logic [PF:0] t1_d_r [1:6];

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d_r[1] <= t0;
      t1_d_r[1] <= t1;
      for (int k = 2; k <= 6; k++) begin
        t0_d_r[k] <= t0_d_r[k-1];
        t1_d_r[k] <= t1_d_r[k-1];
      end
    end
  end

  // level 1: a00 a01 a02 at t0, a10 a11 a12 at t1
  logic [CW-1:0] pv [4];
  logic [CW-1:0] l1 [6];
  assign pv[0] = p0;
  assign pv[1] = p1;
  assign pv[2] = p2;
  assign pv[3] = p3;

  for (genvar i = 0; i < 6; i++) begin : g_l1
    cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_lerp (
      .clk(clk), .en(en), .a(pv[i % 3]), .b(pv[i % 3 + 1]),
      .t((i < 3) ? t0 : t1), .y(l1[i])
    );
  end

  // level 2
  logic [CW-1:0] b000, b001, b010, b011, b110, b111;
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_b000 (
    .clk(clk), .en(en), .a(l1[0]), .b(l1[1]), .t(t0_d_r[3]), .y(b000));
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_b001 (
    .clk(clk), .en(en), .a(l1[1]), .b(l1[2]), .t(t0_d_r[3]), .y(b001));
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_b010 (
    .clk(clk), .en(en), .a(l1[0]), .b(l1[1]), .t(t1_d_r[3]), .y(b010));
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_b011 (
    .clk(clk), .en(en), .a(l1[1]), .b(l1[2]), .t(t1_d_r[3]), .y(b011));
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_b110 (
    .clk(clk), .en(en), .a(l1[3]), .b(l1[4]), .t(t1_d_r[3]), .y(b110));
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_b111 (
    .clk(clk), .en(en), .a(l1[4]), .b(l1[5]), .t(t1_d_r[3]), .y(b111));

  // level 3: restricted control values, ready after stage 9
  logic [CW-1:0] q9 [4];
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_q0 (
    .clk(clk), .en(en), .a(b000), .b(b001), .t(t0_d_r[6]), .y(q9[0]));
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_q1 (
    .clk(clk), .en(en), .a(b000), .b(b001), .t(t1_d_r[6]), .y(q9[1]));
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_q2 (
    .clk(clk), .en(en), .a(b010), .b(b011), .t(t1_d_r[6]), .y(q9[2]));
  cbsb_lerp #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_q3 (
    .clk(clk), .en(en), .a(b110), .b(b111), .t(t1_d_r[6]), .y(q9[3]));

  // margin path, stages 1 to 4, then delayed to the extent stages
  logic [CW-1:0]   mag_r [4];
  logic [CW-1:0]   mx_r, mx_nxt;
  logic [MW-1:0]   mprod_r;
  logic [EW-1:0]   esum;
  logic [CW-2:0]   e_nxt;
  logic [CW-2:0]   e_d_r [4:12];

  always_comb begin
    mx_nxt = mag_r[0];
    for (int k = 1; k < 4; k++)
      if (mag_r[k] > mx_nxt) mx_nxt = mag_r[k];
    esum = EW'(mprod_r >> MarginShift)
         + EW'(|mprod_r[MarginShift-1:0])
         + EW'(abs_margin);
    e_nxt = (esum > EMAX) ? EMAX[CW-2:0] : esum[CW-2:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) mag_r[k] <= magn(pv[k]);
      mx_r    <= mx_nxt;
      mprod_r <= MW'(mx_r) * MW'(rel_margin);
      e_d_r[4] <= e_nxt;
      for (int k = 5; k <= 12; k++) e_d_r[k] <= e_d_r[k-1];
    end
  end

  // stage 10: control differences, hull, first mid level
  logic signed [CW:0] d_r [3];
  logic [CW-1:0]      qmin_r, qmax_r, qmin_nxt, qmax_nxt;
  logic [CW-1:0]      q10_r [4];
  logic [CW-1:0]      ma_r [3];

  always_comb begin
    qmin_nxt = q9[0];
    qmax_nxt = q9[0];
    for (int k = 1; k < 4; k++) begin
      if ($signed(q9[k]) < $signed(qmin_nxt)) qmin_nxt = q9[k];
      if ($signed(q9[k]) > $signed(qmax_nxt)) qmax_nxt = q9[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k]  <= $signed({q9[k+1][CW-1], q9[k+1]}) - $signed({q9[k][CW-1], q9[k]});
        ma_r[k] <= half_lerp(q9[k], q9[k+1]);
      end
      for (int k = 0; k < 4; k++) q10_r[k] <= q9[k];
      qmin_r <= qmin_nxt;
      qmax_r <= qmax_nxt;
    end
  end

  // stage 11: monotone test against 4e, choose the bounds before widening
  logic signed [GW-1:0] g, ng;
  logic                 up, dn;
  logic [CW-1:0]        lo_pre_r, hi_pre_r, lo_pre_nxt, hi_pre_nxt;
  logic [CW-1:0]        q11_r [4];
  logic [CW-1:0]        mb_r [2];

  always_comb begin
    g  = $signed({2'b00, e_d_r[10], 2'b00});
    ng = -g;
    up = 1'b1;
    dn = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if ($signed({{2{d_r[k][CW]}}, d_r[k]}) < g)  up = 1'b0;
      if ($signed({{2{d_r[k][CW]}}, d_r[k]}) > ng) dn = 1'b0;
    end
    if (up) begin
      lo_pre_nxt = q10_r[0];
      hi_pre_nxt = q10_r[3];
    end else if (dn) begin
      lo_pre_nxt = q10_r[3];
      hi_pre_nxt = q10_r[0];
    end else begin
      lo_pre_nxt = qmin_r;
      hi_pre_nxt = qmax_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_pre_r <= lo_pre_nxt;
      hi_pre_r <= hi_pre_nxt;
      for (int k = 0; k < 4; k++) q11_r[k] <= q10_r[k];
      mb_r[0] <= half_lerp(ma_r[0], ma_r[1]);
      mb_r[1] <= half_lerp(ma_r[1], ma_r[2]);
    end
  end

  // stage 12: widen by e with saturation, last mid level
  logic [CW-1:0] q12_r [4];
  logic [CW-1:0] lo_r, hi_r, mid_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) q12_r[k] <= q11_r[k];
      lo_r  <= sat_sum($signed({lo_pre_r[CW-1], lo_pre_r}) - $signed({2'b00, e_d_r[11]}));
      hi_r  <= sat_sum($signed({hi_pre_r[CW-1], hi_pre_r}) + $signed({2'b00, e_d_r[11]}));
      mid_r <= half_lerp(mb_r[0], mb_r[1]);
    end
  end

  assign q0     = q12_r[0];
  assign q1     = q12_r[1];
  assign q2     = q12_r[2];
  assign q3     = q12_r[3];
  assign ext_lo = lo_r;
  assign ext_hi = hi_r;
  assign mid    = mid_r;
  assign margin = e_d_r[12];

endmodule

FILE: rtl/cbsb_merge.sv
// Merge stage: takes both lane results at once and sends x, then y.
// Depends on cbsb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cubic_bezier_subcurve_bounds_unit_assert.svh"

module cbsb_merge
  import cbsb_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [8*COORD_WIDTH-2:0]   x_res,
  input  logic [8*COORD_WIDTH-2:0]   y_res,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       out_y,
  output logic [8*COORD_WIDTH-2:0]   out_res,
  output logic                       ready
);

  localparam int RW = 8 * COORD_WIDTH - 1;

  logic          v_r, v_nxt;
  logic          y_r, y_nxt;
  logic [RW-1:0] x_res_r, y_res_r;
  logic          beat;

  always_comb begin
    beat  = v_r && !out_stall;
    ready = !v_r || (y_r && !out_stall);
    v_nxt = v_r;
    y_nxt = y_r;
    if (load) begin
      v_nxt = 1'b1;
      y_nxt = 1'b0;
    end else if (beat) begin
      if (!y_r) y_nxt = 1'b1;
      else      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      y_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      y_r <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_res_r <= x_res;
      y_res_r <= y_res;
    end
  end

  assign out_valid = v_r;
  assign out_y     = y_r;
  assign out_res   = y_r ? y_res_r : x_res_r;

  `CBSB_ASSERT_NEXT(a_x_then_y, clk, rst_n, beat && !y_r, v_r && y_r, "x result not followed by y")
  `CBSB_ASSERT_SAME(a_load_when_free, clk, rst_n, load, !v_r || (y_r && beat), "pair overwritten")
  `CBSB_ASSERT_NEXT(a_load_starts_x, clk, rst_n, load, v_r && !y_r, "new pair does not start on x")
  `CBSB_ASSERT_NEXT(a_drain, clk, rst_n, beat && y_r && !load, !v_r, "result repeated")

endmodule

FILE: rtl/cubic_bezier_subcurve_bounds_unit.sv
// Top level of the cubic Bezier subcurve bounds unit.
// Depends on cbsb_pkg, cbsb_lane (with cbsb_lerp) and cbsb_merge.
`timescale 1ns / 1ps

// Takes one cubic Bezier (four 2D control points) and an interval t0..t1 per
// transaction and returns two results, x first then y (is_last set on y), each
// with the restricted control values, the mid value, margin e and the widened
// extent. Parameters above one are clamped to one; t0 > t1 is not swapped.
// Two identical axis lanes run side by side, 12 pipeline stages deep (three
// pipelined lerp levels plus extent and mid stages), then a merge register
// that serializes the pair onto the single result port. Since that port carries
// two results per transaction, input is taken no faster than pairs are sent, and
// out_stall holds the lanes back through in_stall. Configuration writes are
// always ready.

module cubic_bezier_subcurve_bounds_unit
  import cbsb_pkg::*;
#(
  parameter int COORD_WIDTH     = CoordWidthDef,
  parameter int PARAM_FRAC_BITS = ParamFracDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CfgIdxW-1:0]            cfg_index,
  input  logic [CfgW-1:0]               cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_handle1_x,
  input  logic signed [COORD_WIDTH-1:0] in_handle1_y,
  input  logic signed [COORD_WIDTH-1:0] in_handle2_x,
  input  logic signed [COORD_WIDTH-1:0] in_handle2_y,
  input  logic signed [COORD_WIDTH-1:0] in_finish_x,
  input  logic signed [COORD_WIDTH-1:0] in_finish_y,
  input  logic [PARAM_FRAC_BITS:0]      in_param_from,
  input  logic [PARAM_FRAC_BITS:0]      in_param_to,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_axis_sel,
  output logic signed [COORD_WIDTH-1:0] out_piece_q0,
  output logic signed [COORD_WIDTH-1:0] out_piece_q1,
  output logic signed [COORD_WIDTH-1:0] out_piece_q2,
  output logic signed [COORD_WIDTH-1:0] out_piece_q3,
  output logic signed [COORD_WIDTH-1:0] out_extent_low,
  output logic signed [COORD_WIDTH-1:0] out_extent_high,
  output logic signed [COORD_WIDTH-1:0] out_mid_value,
  output logic [COORD_WIDTH-2:0]        out_margin,
  output logic                          out_is_last
);

  localparam int CW = COORD_WIDTH;
  localparam int PF = PARAM_FRAC_BITS;
  localparam int RW = 8 * CW - 1;
  localparam logic [PF:0] PONE = {1'b1, {PF{1'b0}}};

  function automatic logic [PF:0] clamp_t(input logic [PF:0] v);
    clamp_t = (v > PONE) ? PONE : v;
  endfunction

  // configuration registers
  logic [CfgW-1:0] rel_r, rel_nxt;
  logic [CfgW-1:0] abs_r, abs_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    rel_nxt = rel_r;
    abs_nxt = abs_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_REL_MARGIN: rel_nxt = cfg_data;
        CFG_ABS_MARGIN: abs_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r <= RelMarginReset;
      abs_r <= AbsMarginReset;
    end else begin
      rel_r <= rel_nxt;
      abs_r <= abs_nxt;
    end
  end

  // lane pipeline control: whole pipe advances unless the last stage is blocked
  logic                 adv;
  logic                 merge_ready;
  logic [LaneDepth-1:0] vld_r, vld_nxt;
  logic [PF:0]          t0c, t1c;

  assign adv      = !vld_r[LaneDepth-1] || merge_ready;
  assign in_stall = !adv;
  assign t0c      = clamp_t(in_param_from);
  assign t1c      = clamp_t(in_param_to);

  always_comb begin
    vld_nxt = vld_r;
    if (adv) vld_nxt = {vld_r[LaneDepth-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  logic [CW-1:0] xq0, xq1, xq2, xq3, xlo, xhi, xmid;
  logic [CW-1:0] yq0, yq1, yq2, yq3, ylo, yhi, ymid;
  logic [CW-2:0] xe, ye;

  cbsb_lane #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_lane_x (
    .clk(clk), .en(adv),
    .p0(in_start_x), .p1(in_handle1_x), .p2(in_handle2_x), .p3(in_finish_x),
    .t0(t0c), .t1(t1c), .rel_margin(rel_r), .abs_margin(abs_r),
    .q0(xq0), .q1(xq1), .q2(xq2), .q3(xq3),
    .ext_lo(xlo), .ext_hi(xhi), .mid(xmid), .margin(xe)
  );

  cbsb_lane #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) u_lane_y (
    .clk(clk), .en(adv),
    .p0(in_start_y), .p1(in_handle1_y), .p2(in_handle2_y), .p3(in_finish_y),
    .t0(t0c), .t1(t1c), .rel_margin(rel_r), .abs_margin(abs_r),
    .q0(yq0), .q1(yq1), .q2(yq2), .q3(yq3),
    .ext_lo(ylo), .ext_hi(yhi), .mid(ymid), .margin(ye)
  );

  logic [RW-1:0] x_res, y_res, o_res;
  logic          o_y;

  assign x_res = {xq0, xq1, xq2, xq3, xlo, xhi, xmid, xe};
  assign y_res = {yq0, yq1, yq2, yq3, ylo, yhi, ymid, ye};

  cbsb_merge #(.COORD_WIDTH(CW)) u_merge (
    .clk(clk), .rst_n(rst_n),
    .load(vld_r[LaneDepth-1] && merge_ready),
    .x_res(x_res), .y_res(y_res),
    .out_stall(out_stall), .out_valid(out_valid), .out_y(o_y),
    .out_res(o_res), .ready(merge_ready)
  );

  assign out_axis_sel    = o_y;
  assign out_is_last     = o_y;
  assign out_piece_q0    = o_res[RW-1 -: CW];
  assign out_piece_q1    = o_res[RW-1-CW -: CW];
  assign out_piece_q2    = o_res[RW-1-2*CW -: CW];
  assign out_piece_q3    = o_res[RW-1-3*CW -: CW];
  assign out_extent_low  = o_res[RW-1-4*CW -: CW];
  assign out_extent_high = o_res[RW-1-5*CW -: CW];
  assign out_mid_value   = o_res[RW-1-6*CW -: CW];
  assign out_margin      = o_res[CW-2:0];

endmodule
